FILE: hdl/adam_pkg.sv
// Shared widths, constants, register indexes and helpers of the Adam update block.
// No dependencies; adam_if and adam_optimizer_update import this package.
`timescale 1ns / 1ps
`default_nettype none
package adam_pkg;
	localparam int NUM_PARAMS = 4096;
	localparam int IDX_W      = 12;
	localparam int ADDR_W     = $clog2(NUM_PARAMS);
	localparam int DATA_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 32;

	localparam int LR_W    = 32;
	localparam int BETA_W  = 24;
	localparam int EPS_W   = 16;
	localparam int POW_W   = 25;
	localparam int SCALE_W = 48;
	localparam int CR_W    = 25;
	localparam int CHG_W   = 40;

	localparam int MUL_A_W   = 57;
	localparam int MUL_B_W   = 48;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int DIGIT_W   = 4;
	localparam int MUL_STEPS = MUL_B_W / DIGIT_W;
	localparam int SQ_RAD_W  = 64;
	localparam int SQ_STEPS  = SQ_RAD_W / 2;
	localparam int DIV_D_W   = 61;
	localparam int DIV_STEPS = MUL_P_W;
	localparam int CNT_W     = 7;

	localparam logic [POW_W-1:0] ONE_Q24  = 25'h1000000;
	localparam int               HALF_Q24 = 8388608;

	localparam logic [LR_W-1:0]   LR_RST  = 32'd4294967;
	localparam logic [BETA_W-1:0] B1_RST  = 24'd15099494;
	localparam logic [BETA_W-1:0] B2_RST  = 24'd16760439;
	localparam logic [EPS_W-1:0]  EPS_RST = 16'd43;

	localparam logic [CFG_IDX_W-1:0] CFG_LR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B1  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B2  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EPS = 2'd3;

	typedef struct packed {
		logic signed [DATA_W-1:0] m;
		logic [DATA_W-1:0]        v;
	} mom_t;

	// Clamps a wide signed value to the signed data range.
	function automatic logic [DATA_W-1:0] sat_data(input logic signed [41:0] x);
		logic signed [41:0] hi;
		logic signed [41:0] lo;
		hi = 42'sd2147483647;
		lo = -42'sd2147483648;
		if (x > hi) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end else if (x < lo) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end
		return x[DATA_W-1:0];
	endfunction
endpackage
`default_nettype wire

FILE: hdl/adam_if.sv
// Handshake channels of the Adam update block: input items, result items, register writes.
// Depends on adam_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface adam_in_if;
	import adam_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [IDX_W-1:0]         index;
	logic signed [DATA_W-1:0] param_in;
	logic signed [DATA_W-1:0] gradient;
	logic                     first_of_step;
	modport source(output valid, kind, index, param_in, gradient, first_of_step, input ready);
	modport sink(input valid, kind, index, param_in, gradient, first_of_step, output ready);
endinterface

interface adam_out_if;
	import adam_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         out_index;
	logic signed [DATA_W-1:0] param_out;
	modport source(output valid, out_index, param_out, input ready);
	modport sink(input valid, out_index, param_out, output ready);
endinterface

interface adam_cfg_if;
	import adam_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/adam_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module adam_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: hdl/adam_optimizer_update.sv
// Adam parameter update: one element per item, moments held in an on-chip RAM.
// Depends on adam_pkg, adam_if (channels) and adam_ram (moment store).
//
// Items are handled one at a time. An item that opens a new step first advances the
// powers, the step scale and the correction root, then does the update. The work is done
// by one radix-16 serial multiplier (eight products per element), a two-bit-per-cycle
// square root unit and a one-bit-per-cycle restoring divider.
// After reset and after each reset item the block clears all 4096 entries of the moment
// RAM, one entry per cycle, during which it takes no item; register writes are always taken.
// A finished result waits in an output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module adam_optimizer_update (
	input  logic       clk,
	input  logic       arst_n,
	adam_cfg_if.sink   cfg,
	adam_in_if.sink    item_in,
	adam_out_if.source item_out
);
	import adam_pkg::*;

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_READ  = 5'd2;
	localparam logic [4:0] S_B1    = 5'd3;
	localparam logic [4:0] S_B2    = 5'd4;
	localparam logic [4:0] S_SC    = 5'd5;
	localparam logic [4:0] S_CR    = 5'd6;
	localparam logic [4:0] S_M1    = 5'd7;
	localparam logic [4:0] S_M2    = 5'd8;
	localparam logic [4:0] S_G2    = 5'd9;
	localparam logic [4:0] S_V1    = 5'd10;
	localparam logic [4:0] S_V2    = 5'd11;
	localparam logic [4:0] S_N1    = 5'd12;
	localparam logic [4:0] S_N2    = 5'd13;
	localparam logic [4:0] S_E1    = 5'd14;
	localparam logic [4:0] S_SQ    = 5'd15;
	localparam logic [4:0] S_DV    = 5'd16;
	localparam logic [4:0] S_FIN   = 5'd17;

	logic [4:0]        st_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] clr_q;
	logic              out_valid_q;

	logic [LR_W-1:0]    lr_q;
	logic [BETA_W-1:0]  b1_q;
	logic [BETA_W-1:0]  b2_q;
	logic [EPS_W-1:0]   eps_q;
	logic [POW_W-1:0]   pow1_q;
	logic [POW_W-1:0]   pow2_q;
	logic [SCALE_W-1:0] scale_q;
	logic [CR_W-1:0]    cr_q;

	logic [IDX_W-1:0]         idx_q;
	logic signed [DATA_W-1:0] param_q;
	logic signed [DATA_W-1:0] grad_q;
	logic                     fos_q;
	logic signed [DATA_W-1:0] m_old_q;
	logic [DATA_W-1:0]        v_old_q;
	logic [55:0]              pa_q;
	logic signed [DATA_W-1:0] m_new_q;
	logic [DATA_W-1:0]        g2_q;
	logic [DATA_W-1:0]        v_new_q;
	logic [MUL_A_W-1:0]       num_q;
	logic                     nz_q;
	logic [16:0]              eps_t_q;
	logic [CHG_W-1:0]         chg_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic [DATA_W-1:0]        out_param_q;

	logic [MUL_A_W-1:0] mul_a_q;
	logic [MUL_B_W-1:0] mul_b_q;
	logic [MUL_P_W-1:0] acc_q;
	logic [SQ_RAD_W-1:0] sq_rad_q;
	logic [34:0]         sq_rem_q;
	logic [31:0]         sq_root_q;
	logic [MUL_P_W-1:0]  dv_dvd_q;
	logic [DIV_D_W-1:0]  dv_d_q;
	logic [DIV_D_W-1:0]  dv_rem_q;
	logic [SCALE_W-1:0]  dv_q_q;
	logic                dv_sat_q;

	logic                in_acc;
	logic                is_mul;
	logic                is_sq;
	logic                is_dv;
	logic [CNT_W-1:0]    last_cnt;
	logic                ld;
	logic                fin;
	logic                step;
	logic [MUL_A_W-1:0]  op_a;
	logic [MUL_B_W-1:0]  op_b;
	logic [60:0]         mul_part;
	logic [60:0]         mul_sum;
	logic [34:0]         sq_rem_n;
	logic [34:0]         sq_trial;
	logic                sq_ge;
	logic [61:0]         dv_rem_n;
	logic [61:0]         dv_diff;
	logic                dv_ge;
	logic [POW_W-1:0]    omb1;
	logic [POW_W-1:0]    omb2;
	logic [POW_W-1:0]    bc1;
	logic [POW_W-1:0]    bc2;
	logic [49:0]         pow_sum;
	logic [DATA_W-1:0]   m_old_mag;
	logic [DATA_W-1:0]   g_mag;
	logic [DATA_W-1:0]   m_new_mag;
	logic signed [57:0]  t1;
	logic signed [57:0]  t2;
	logic signed [57:0]  m_sum;
	logic [DATA_W-1:0]   m_sat;
	logic [64:0]         g2_sum;
	logic [DATA_W-1:0]   g2_sat;
	logic [57:0]         v_sum;
	logic [DATA_W-1:0]   v_sat;
	logic [36:0]         den;
	logic [CHG_W-1:0]    chg_d;
	logic [SCALE_W-1:0]  scale_d;
	logic signed [41:0]  p_ext;
	logic signed [41:0]  p_res;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	mom_t                ram_wdata;
	mom_t                ram_rdata;
	mom_t                new_mom;

	assign in_acc = item_in.valid && item_in.ready;
	assign item_in.ready = (st_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign item_out.valid = out_valid_q;
	assign item_out.out_index = out_idx_q;
	assign item_out.param_out = out_param_q;

	assign is_mul = (st_q == S_B1) || (st_q == S_B2) || (st_q == S_M1) || (st_q == S_M2) ||
		(st_q == S_G2) || (st_q == S_V1) || (st_q == S_V2) || (st_q == S_N1) ||
		(st_q == S_N2) || (st_q == S_E1);
	assign is_sq = (st_q == S_CR) || (st_q == S_SQ);
	assign is_dv = (st_q == S_SC) || (st_q == S_DV);
	assign last_cnt = is_mul ? CNT_W'(MUL_STEPS + 1) :
		(is_sq ? CNT_W'(SQ_STEPS + 1) : CNT_W'(DIV_STEPS + 1));
	assign ld = (cnt_q == '0);
	assign fin = (cnt_q == last_cnt);
	assign step = !ld && !fin;

	assign omb1 = ONE_Q24 - POW_W'(b1_q);
	assign omb2 = ONE_Q24 - POW_W'(b2_q);
	assign bc1 = ONE_Q24 - pow1_q;
	assign bc2 = ONE_Q24 - pow2_q;
	assign m_old_mag = m_old_q[DATA_W-1] ? DATA_W'(-m_old_q) : DATA_W'(m_old_q);
	assign g_mag = grad_q[DATA_W-1] ? DATA_W'(-grad_q) : DATA_W'(grad_q);
	assign m_new_mag = m_new_q[DATA_W-1] ? DATA_W'(-m_new_q) : DATA_W'(m_new_q);

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (st_q)
			S_B1: begin
				op_a = MUL_A_W'(pow1_q);
				op_b = MUL_B_W'(b1_q);
			end
			S_B2: begin
				op_a = MUL_A_W'(pow2_q);
				op_b = MUL_B_W'(b2_q);
			end
			S_M1: begin
				op_a = MUL_A_W'(m_old_mag);
				op_b = MUL_B_W'(b1_q);
			end
			S_M2: begin
				op_a = MUL_A_W'(g_mag);
				op_b = MUL_B_W'(omb1);
			end
			S_G2: begin
				op_a = MUL_A_W'(g_mag);
				op_b = MUL_B_W'(g_mag);
			end
			S_V1: begin
				op_a = MUL_A_W'(v_old_q);
				op_b = MUL_B_W'(b2_q);
			end
			S_V2: begin
				op_a = MUL_A_W'(g2_q);
				op_b = MUL_B_W'(omb2);
			end
			S_N1: begin
				op_a = MUL_A_W'(m_new_mag);
				op_b = MUL_B_W'(cr_q);
			end
			S_N2: begin
				op_a = num_q;
				op_b = scale_q;
			end
			S_E1: begin
				op_a = MUL_A_W'(eps_q);
				op_b = MUL_B_W'(cr_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_part = 61'(mul_a_q) * 61'(mul_b_q[DIGIT_W-1:0]);
	assign mul_sum = 61'(acc_q[MUL_P_W-1:MUL_B_W]) + mul_part;

	assign sq_rem_n = {sq_rem_q[32:0], sq_rad_q[SQ_RAD_W-1:SQ_RAD_W-2]};
	assign sq_trial = {1'b0, sq_root_q, 2'b01};
	assign sq_ge = (sq_rem_n >= sq_trial);

	assign dv_rem_n = {dv_rem_q, dv_dvd_q[MUL_P_W-1]};
	assign dv_diff = dv_rem_n - {1'b0, dv_d_q};
	assign dv_ge = (dv_rem_n >= {1'b0, dv_d_q});

	assign pow_sum = acc_q[49:0] + 50'(HALF_Q24);

	assign t1 = m_old_q[DATA_W-1] ? -58'(pa_q) : 58'(pa_q);
	assign t2 = grad_q[DATA_W-1] ? -58'(acc_q[55:0]) : 58'(acc_q[55:0]);
	assign m_sum = t1 + t2 + 58'(HALF_Q24);
	assign m_sat = sat_data(42'(m_sum >>> 24));

	assign g2_sum = 65'(acc_q[63:0]) + 65'(HALF_Q24);
	assign g2_sat = (|g2_sum[64:56]) ? '1 : g2_sum[55:24];

	assign v_sum = 58'(pa_q) + 58'(acc_q[55:0]) + 58'(HALF_Q24);
	assign v_sat = (|v_sum[57:56]) ? '1 : v_sum[55:24];

	assign den = 37'({sq_root_q, 4'b0}) + 37'(eps_t_q);
	assign chg_d = !nz_q ? '0 : ((dv_sat_q || (|dv_q_q[SCALE_W-1:CHG_W])) ? '1 :
		dv_q_q[CHG_W-1:0]);
	assign scale_d = dv_sat_q ? '1 : dv_q_q;

	assign p_ext = 42'(param_q);
	assign p_res = m_new_q[DATA_W-1] ? (p_ext + 42'(chg_q)) : (p_ext - 42'(chg_q));

	assign new_mom.m = m_new_q;
	assign new_mom.v = v_sat;
	assign ram_we = (st_q == S_CLEAR) || ((st_q == S_V2) && fin);
	assign ram_waddr = (st_q == S_CLEAR) ? clr_q : idx_q[ADDR_W-1:0];
	assign ram_wdata = (st_q == S_CLEAR) ? mom_t'('0) : new_mom;

	adam_ram #(
		.WIDTH($bits(mom_t)),
		.DEPTH(NUM_PARAMS)
	) u_mom_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_acc),
		.raddr(item_in.index[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			cnt_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			lr_q <= LR_RST;
			b1_q <= B1_RST;
			b2_q <= B2_RST;
			eps_q <= EPS_RST;
			pow1_q <= ONE_Q24;
			pow2_q <= ONE_Q24;
			scale_q <= '0;
			cr_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_LR:  lr_q <= cfg.data[LR_W-1:0];
					CFG_B1:  b1_q <= cfg.data[BETA_W-1:0];
					CFG_B2:  b2_q <= cfg.data[BETA_W-1:0];
					CFG_EPS: eps_q <= cfg.data[EPS_W-1:0];
					default: ;
				endcase
			end
			if (item_out.valid && item_out.ready && (st_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			if (is_mul || is_sq || is_dv) begin
				cnt_q <= fin ? '0 : cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(NUM_PARAMS - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (item_in.kind) begin
							st_q <= S_CLEAR;
							clr_q <= '0;
							pow1_q <= ONE_Q24;
							pow2_q <= ONE_Q24;
							scale_q <= '0;
							cr_q <= '0;
						end else if ({1'b0, item_in.index} < (IDX_W + 1)'(NUM_PARAMS)) begin
							st_q <= S_READ;
						end
					end
				end
				S_READ: st_q <= fos_q ? S_B1 : S_M1;
				S_B1: begin
					if (fin) begin
						pow1_q <= pow_sum[48:24];
						st_q <= S_B2;
					end
				end
				S_B2: begin
					if (fin) begin
						pow2_q <= pow_sum[48:24];
						st_q <= S_SC;
					end
				end
				S_SC: begin
					if (fin) begin
						scale_q <= scale_d;
						st_q <= S_CR;
					end
				end
				S_CR: begin
					if (fin) begin
						cr_q <= sq_root_q[CR_W-1:0];
						st_q <= S_M1;
					end
				end
				S_M1: if (fin) st_q <= S_M2;
				S_M2: if (fin) st_q <= S_G2;
				S_G2: if (fin) st_q <= S_V1;
				S_V1: if (fin) st_q <= S_V2;
				S_V2: if (fin) st_q <= S_N1;
				S_N1: if (fin) st_q <= S_N2;
				S_N2: if (fin) st_q <= S_E1;
				S_E1: if (fin) st_q <= S_SQ;
				S_SQ: if (fin) st_q <= S_DV;
				S_DV: if (fin) st_q <= S_FIN;
				S_FIN: begin
					if (!out_valid_q || item_out.ready) begin
						out_valid_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q <= item_in.index;
			param_q <= item_in.param_in;
			grad_q <= item_in.gradient;
			fos_q <= item_in.first_of_step;
		end
		if (st_q == S_READ) begin
			m_old_q <= ram_rdata.m;
			v_old_q <= ram_rdata.v;
		end
		if (fin && ((st_q == S_M1) || (st_q == S_V1))) begin
			pa_q <= acc_q[55:0];
		end
		if (fin && (st_q == S_M2)) begin
			m_new_q <= m_sat;
		end
		if (fin && (st_q == S_G2)) begin
			g2_q <= g2_sat;
		end
		if (fin && (st_q == S_V2)) begin
			v_new_q <= v_sat;
		end
		if (fin && (st_q == S_N1)) begin
			num_q <= acc_q[MUL_A_W-1:0];
		end
		if (fin && (st_q == S_N2)) begin
			nz_q <= (acc_q != '0);
		end
		if (fin && (st_q == S_E1)) begin
			eps_t_q <= acc_q[40:24];
		end
		if (fin && (st_q == S_DV)) begin
			chg_q <= chg_d;
		end
		if ((st_q == S_FIN) && (!out_valid_q || item_out.ready)) begin
			out_idx_q <= idx_q;
			out_param_q <= sat_data(p_res);
		end

		if (is_mul && ld) begin
			mul_a_q <= op_a;
			mul_b_q <= op_b;
			acc_q <= '0;
		end else if (is_mul && step) begin
			acc_q <= {mul_sum, acc_q[MUL_B_W-1:DIGIT_W]};
			mul_b_q <= mul_b_q >> DIGIT_W;
		end

		if (is_sq && ld) begin
			sq_rad_q <= (st_q == S_CR) ? {15'b0, bc2, 24'b0} : {v_new_q, 32'b0};
			sq_rem_q <= '0;
			sq_root_q <= '0;
		end else if (is_sq && step) begin
			sq_rem_q <= sq_ge ? (sq_rem_n - sq_trial) : sq_rem_n;
			sq_root_q <= {sq_root_q[30:0], sq_ge};
			sq_rad_q <= sq_rad_q << 2;
		end

		if (fin && (st_q == S_N2)) begin
			dv_dvd_q <= acc_q;
		end else if ((st_q == S_SC) && ld) begin
			dv_dvd_q <= {49'b0, lr_q, 24'b0};
		end else if (is_dv && step) begin
			dv_dvd_q <= dv_dvd_q << 1;
		end
		if (is_dv && ld) begin
			dv_d_q <= (st_q == S_SC) ? DIV_D_W'(bc1) : {den, 24'b0};
			dv_rem_q <= '0;
			dv_q_q <= '0;
			dv_sat_q <= 1'b0;
		end else if (is_dv && step) begin
			dv_rem_q <= dv_ge ? dv_diff[DIV_D_W-1:0] : dv_rem_n[DIV_D_W-1:0];
			dv_sat_q <= dv_sat_q | dv_q_q[SCALE_W-1];
			dv_q_q <= {dv_q_q[SCALE_W-2:0], dv_ge};
		end
	end

	a_reset_item_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && item_in.kind) |=> (st_q == S_CLEAR))
		else $error("reset item did not start the clearing pass");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> !ram_we)
		else $error("moment RAM written while idle");

	a_pow_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pow1_q <= ONE_Q24) && (pow2_q <= ONE_Q24))
		else $error("beta power above one");

	a_result_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == S_FIN) && (!out_valid_q || item_out.ready)) |=> out_valid_q)
		else $error("finished item did not reach the output register");
endmodule
`default_nettype wire
